// ----- hw/rtl/kpg_pkg.sv -----
// ----------------------------------------------------------------------------
// kpg_pkg
// Shared types and constants for the k-permutation generator core.
// ----------------------------------------------------------------------------
package kpg_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;

   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHABET_SIZE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LENGTH_IN_USE = 2'd1;

   localparam logic [4:0] ALPHABET_SIZE_RESET = 5'd16;
   localparam logic [3:0] LENGTH_IN_USE_RESET = 4'd1;

   localparam logic [6:0] LETTER_BASE = 7'd97;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_BACK,
      ST_SCAN,
      ST_EMIT,
      ST_EXH
   } kpg_state_type;

endpackage

// ----- hw/rtl/k_permutation_generator_core.sv -----
// ----------------------------------------------------------------------------
// k_permutation_generator_core
// Enumerates arrangements without repetition in lexicographic order, one
// letter per transfer, using a small sequencer over a position array and a
// used-letter mask.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_restart
//   rsp      out        rsp_valid/rsp_stall  rsp_letter, rsp_last_letter,
//                                            rsp_exhausted
//   csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One request at a time; req_stall is high from the cycle after acceptance
// until the last letter transfers. First arrangement: accept, fill every
// position, then emit the letters. Next arrangement: back up positions and
// try candidates, then refill, placing letters and skipping used ones, then
// emit. Synchronous active-high reset clears control state; rsp stalls hold
// the current letter.
// ----------------------------------------------------------------------------
module k_permutation_generator_core
   import kpg_pkg::*;
#(
   parameter int MAX_SYMBOLS = 16,
   parameter int MAX_LENGTH  = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_restart,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [6:0]             rsp_letter,
   output logic                   rsp_last_letter,
   output logic                   rsp_exhausted,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int SW  = (MAX_SYMBOLS > 2) ? $clog2(MAX_SYMBOLS) : 1;
   localparam int CW  = $clog2(MAX_SYMBOLS + 1);
   localparam int PW  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
   localparam int PCW = $clog2(MAX_LENGTH + 1);

   kpg_state_type state_ff, state_in;

   logic [4:0]             alph_ff, alph_in;
   logic [3:0]             len_cfg_ff, len_cfg_in;
   logic [MAX_SYMBOLS-1:0] used_ff, used_in;
   logic                   started_ff, started_in;
   logic                   finished_ff, finished_in;
   logic [PCW-1:0]         pos_ff, pos_in;
   logic [CW-1:0]          cand_ff, cand_in;
   logic [PW-1:0]          emit_ff, emit_in;
   logic [SW-1:0]          chosen_ff [MAX_LENGTH];

   logic                   wr_en;
   logic [PW-1:0]          wr_addr;
   logic [SW-1:0]          wr_data;
   logic [PW-1:0]          rd_addr;
   logic [SW-1:0]          rd_data;

   logic [CW-1:0]          syms;
   logic [PCW-1:0]         len;
   logic [PCW-1:0]         pos_m1;
   logic                   req_xfer;
   logic                   rsp_xfer;
   logic                   csr_xfer;
   logic                   no_arrangement;
   logic                   eff_started;
   logic                   eff_finished;
   logic                   cand_ok;
   logic                   cand_used;
   logic                   emit_last;

   assign syms = (32'(alph_ff) > MAX_SYMBOLS) ? CW'(MAX_SYMBOLS) : CW'(alph_ff);
   assign len  = (32'(len_cfg_ff) > MAX_LENGTH) ? PCW'(MAX_LENGTH) : PCW'(len_cfg_ff);

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid && !rsp_stall;
   assign csr_xfer = csr_valid && csr_ready;

   assign no_arrangement = (len == '0) || (syms == '0) || (32'(len) > 32'(syms));
   assign eff_started    = started_ff && !req_restart;
   assign eff_finished   = finished_ff && !req_restart;

   assign pos_m1    = pos_ff - PCW'(1);
   assign cand_ok   = cand_ff < syms;
   assign cand_used = cand_ok && used_ff[cand_ff[SW-1:0]];
   assign emit_last = (32'(emit_ff) + 1) == 32'(len);

   assign rd_addr = (state_ff == ST_BACK) ? pos_m1[PW-1:0] : emit_ff;
   assign rd_data = chosen_ff[rd_addr];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (eff_finished || no_arrangement) begin
                  state_in = ST_EXH;
               end else if (!eff_started) begin
                  state_in = ST_FILL;
               end else begin
                  state_in = ST_BACK;
               end
            end
         end
         ST_FILL: begin
            if (pos_ff == len) begin
               state_in = ST_EMIT;
            end
         end
         ST_BACK: begin
            state_in = (pos_ff == '0) ? ST_EXH : ST_SCAN;
         end
         ST_SCAN: begin
            if (!cand_ok) begin
               state_in = ST_BACK;
            end else if (!cand_used) begin
               state_in = ST_FILL;
            end
         end
         ST_EMIT: begin
            if (rsp_xfer && emit_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_EXH: begin
            if (rsp_xfer) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall       = (state_ff != ST_IDLE);
      csr_ready       = (state_ff == ST_IDLE);
      rsp_valid       = (state_ff == ST_EMIT) || (state_ff == ST_EXH);
      rsp_exhausted   = (state_ff == ST_EXH);
      rsp_last_letter = (state_ff == ST_EXH) || emit_last;
      rsp_letter      = (state_ff == ST_EMIT) ? (LETTER_BASE + 7'(rd_data)) : 7'd0;
   end

   // datapath
   always_comb begin
      alph_in     = alph_ff;
      len_cfg_in  = len_cfg_ff;
      used_in     = used_ff;
      started_in  = started_ff;
      finished_in = finished_ff;
      pos_in      = pos_ff;
      cand_in     = cand_ff;
      emit_in     = emit_ff;
      wr_en       = 1'b0;
      wr_addr     = pos_ff[PW-1:0];
      wr_data     = cand_ff[SW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_xfer) begin
               unique case (csr_index)
                  CSR_ALPHABET_SIZE: begin
                     alph_in     = csr_wdata;
                     used_in     = '0;
                     started_in  = 1'b0;
                     finished_in = 1'b0;
                  end
                  CSR_LENGTH_IN_USE: begin
                     len_cfg_in  = csr_wdata[3:0];
                     used_in     = '0;
                     started_in  = 1'b0;
                     finished_in = 1'b0;
                  end
                  default: ;
               endcase
            end
            if (req_xfer) begin
               started_in  = eff_started;
               finished_in = eff_finished;
               if (eff_finished || no_arrangement) begin
                  finished_in = 1'b1;
                  used_in     = '0;
               end else if (!eff_started) begin
                  used_in    = '0;
                  started_in = 1'b1;
                  pos_in     = '0;
                  cand_in    = '0;
               end else begin
                  pos_in = len;
               end
            end
         end
         ST_FILL: begin
            emit_in = '0;
            if (pos_ff != len) begin
               if (cand_used) begin
                  cand_in = cand_ff + CW'(1);
               end else begin
                  wr_en   = 1'b1;
                  wr_data = cand_ok ? cand_ff[SW-1:0] : '0;
                  used_in = used_ff | (MAX_SYMBOLS'(1) << wr_data);
                  cand_in = CW'(wr_data) + CW'(1);
                  pos_in  = pos_ff + PCW'(1);
               end
            end
         end
         ST_BACK: begin
            if (pos_ff == '0) begin
               finished_in = 1'b1;
               used_in     = '0;
            end else begin
               pos_in  = pos_m1;
               used_in = used_ff & ~(MAX_SYMBOLS'(1) << rd_data);
               cand_in = CW'(rd_data) + CW'(1);
            end
         end
         ST_SCAN: begin
            if (cand_ok) begin
               if (cand_used) begin
                  cand_in = cand_ff + CW'(1);
               end else begin
                  wr_en   = 1'b1;
                  used_in = used_ff | (MAX_SYMBOLS'(1) << cand_ff[SW-1:0]);
                  cand_in = '0;
                  pos_in  = pos_ff + PCW'(1);
               end
            end
         end
         ST_EMIT: begin
            if (rsp_xfer) begin
               emit_in = emit_ff + PW'(1);
            end
         end
         ST_EXH: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         alph_ff     <= ALPHABET_SIZE_RESET;
         len_cfg_ff  <= LENGTH_IN_USE_RESET;
         used_ff     <= '0;
         started_ff  <= 1'b0;
         finished_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         alph_ff     <= alph_in;
         len_cfg_ff  <= len_cfg_in;
         used_ff     <= used_in;
         started_ff  <= started_in;
         finished_ff <= finished_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      cand_ff <= cand_in;
      emit_ff <= emit_in;
      if (wr_en) begin
         chosen_ff[wr_addr] <= wr_data;
      end
   end

endmodule
